/* src/gnaf_pkg.sv */
// Package: shared widths, types and constants of the grid adhesion force block.
`default_nettype none
package gnaf_pkg;

   // Field widths
   localparam int CoordW      = 6;
   localparam int MatW        = 3;
   localparam int FillW       = 16;
   localparam int AdhW        = 16;
   localparam int ForceW      = 19;
   localparam int CountW      = 4;
   localparam int CsrIndexW   = 2;
   localparam int CsrDataW    = 64;
   localparam int CellW       = MatW + FillW;

   // Default geometry
   localparam int DefGridWidth     = 64;
   localparam int DefGridHeight    = 64;
   localparam int DefMaterialCount = 8;

   // Square root unit sizing
   localparam int SqrtInW  = 38;
   localparam int SqrtOutW = SqrtInW / 2;
   localparam int SqrtRemW = SqrtOutW + 2;
   localparam int SqrtCntW = $clog2(SqrtOutW + 1);

   // Internal arithmetic
   localparam int AccW       = 21;
   localparam int DiagWeight = 32763;
   localparam int DiagW      = 15;
   localparam int ForceMax   = 262143;
   localparam int ForceMin   = -262144;

   // Command codes
   localparam logic CmdWrite = 1'b0;
   localparam logic CmdQuery = 1'b1;

   // Register indexes
   localparam logic [CsrIndexW-1:0] RegAdhLow  = 2'd0;
   localparam logic [CsrIndexW-1:0] RegAdhHigh = 2'd1;
   localparam logic [CsrIndexW-1:0] RegMinFill = 2'd2;
   localparam logic [FillW-1:0]     MinFillReset = 16'd655;

   // Neighbor offsets, dx outer and dy inner
   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
   } offset_type;

   localparam int NbCount = 8;
   localparam int NbIdxW  = 3;

   function automatic offset_type nb_offset(input logic [NbIdxW-1:0] k);
      offset_type o;
      case (k)
         3'd0: o = '{dx: -2'sd1, dy: -2'sd1};
         3'd1: o = '{dx: -2'sd1, dy:  2'sd0};
         3'd2: o = '{dx: -2'sd1, dy:  2'sd1};
         3'd3: o = '{dx:  2'sd0, dy: -2'sd1};
         3'd4: o = '{dx:  2'sd0, dy:  2'sd1};
         3'd5: o = '{dx:  2'sd1, dy: -2'sd1};
         3'd6: o = '{dx:  2'sd1, dy:  2'sd0};
         default: o = '{dx: 2'sd1, dy: 2'sd1};
      endcase
      return o;
   endfunction

   // Square root unit status
   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage
`default_nettype wire

/* src/gnaf_if.sv */
// Interfaces: request, response and register write channels.
`default_nettype none
interface gnaf_req_if;
   import gnaf_pkg::*;
   logic              valid;
   logic              ready;
   logic              command;
   logic [CoordW-1:0] cell_x;
   logic [CoordW-1:0] cell_y;
   logic [MatW-1:0]   material_code;
   logic [FillW-1:0]  fill_fraction;
   modport source (output valid, command, cell_x, cell_y, material_code, fill_fraction,
                   input ready);
   modport sink   (input valid, command, cell_x, cell_y, material_code, fill_fraction,
                   output ready);
endinterface

interface gnaf_rsp_if;
   import gnaf_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ForceW-1:0] force_x;
   logic signed [ForceW-1:0] force_y;
   logic [ForceW-1:0]        force_magnitude;
   logic [MatW-1:0]          strongest_material;
   logic [CountW-1:0]        contact_total;
   modport source (output valid, force_x, force_y, force_magnitude, strongest_material,
                   contact_total, input ready);
   modport sink   (input valid, force_x, force_y, force_magnitude, strongest_material,
                   contact_total, output ready);
endinterface

interface gnaf_csr_if;
   import gnaf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CsrIndexW-1:0] index;
   logic [CsrDataW-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/gnaf_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module gnaf_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [gnaf_pkg::SqrtInW-1:0]  radicand,
   output gnaf_pkg::sqrt_status_type          status,
   output logic [gnaf_pkg::SqrtOutW-1:0]      root
);
   import gnaf_pkg::*;

   logic [SqrtInW-1:0]  rad_ff, rad_in;
   logic [SqrtRemW-1:0] rem_ff, rem_in;
   logic [SqrtOutW-1:0] root_ff, root_in;
   logic [SqrtCntW-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SqrtRemW+1:0] trial;
   logic [SqrtRemW+2:0] diff;

   // Trial subtract of the next digit pair
   always_comb begin
      trial = {rem_ff, rad_ff[SqrtInW-1 -: 2]};
      diff  = {1'b0, trial} - {3'b000, root_ff, 2'b01};
   end

   // Advance one bit per cycle
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = SqrtCntW'(SqrtOutW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SqrtInW-3:0], 2'b00};
         if (!diff[SqrtRemW+2]) begin
            rem_in  = diff[SqrtRemW-1:0];
            root_in = {root_ff[SqrtOutW-2:0], 1'b1};
         end else begin
            rem_in  = trial[SqrtRemW-1:0];
            root_in = {root_ff[SqrtOutW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status = '{busy: busy_ff, done: done_ff};
   assign root   = root_ff;

endmodule
`default_nettype wire

/* src/grid_neighbor_adhesion_force.sv */
// Grid neighbor adhesion force: cell memory, query sequencer and result register.
// Sequencing: a write is stored at its accepting edge; a query reads its center, then each
// neighbor, and per contact takes a root in the shared square root unit, scales and adds;
// an empty center or off-grid query goes straight to the magnitude root, then the output.
// Throughput: one item at a time; a write every cycle while idle, no item during a query.
// Reset: a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells sets every cell to air.
`default_nettype none
module grid_neighbor_adhesion_force #(
   parameter int GRID_WIDTH     = gnaf_pkg::DefGridWidth,
   parameter int GRID_HEIGHT    = gnaf_pkg::DefGridHeight,
   parameter int MATERIAL_COUNT = gnaf_pkg::DefMaterialCount
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gnaf_req_if.sink    req_chan,
   gnaf_rsp_if.source  rsp_chan,
   gnaf_csr_if.sink    csr_chan
);
   import gnaf_pkg::*;

   localparam int Depth = GRID_WIDTH * GRID_HEIGHT;
   localparam int AddrW = $clog2(Depth);
   localparam int NbW   = 12;

   typedef enum logic [15:0] {
      S_CLEAR     = 16'b0000_0000_0000_0001,
      S_IDLE      = 16'b0000_0000_0000_0010,
      S_CENTER    = 16'b0000_0000_0000_0100,
      S_NB_ADDR   = 16'b0000_0000_0000_1000,
      S_NB_DATA   = 16'b0000_0000_0001_0000,
      S_ADH_MUL   = 16'b0000_0000_0010_0000,
      S_ADH_START = 16'b0000_0000_0100_0000,
      S_ADH_SQRT  = 16'b0000_0000_1000_0000,
      S_SCL_MUL1  = 16'b0000_0001_0000_0000,
      S_SCL_MUL2  = 16'b0000_0010_0000_0000,
      S_DIAG_MUL  = 16'b0000_0100_0000_0000,
      S_ACCUM     = 16'b0000_1000_0000_0000,
      S_MAG_SQ    = 16'b0001_0000_0000_0000,
      S_MAG_START = 16'b0010_0000_0000_0000,
      S_MAG_SQRT  = 16'b0100_0000_0000_0000,
      S_FINISH    = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [CsrDataW-1:0] adh_low_ff, adh_high_ff;
   logic [FillW-1:0]    min_fill_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         adh_low_ff  <= '0;
         adh_high_ff <= '0;
         min_fill_ff <= MinFillReset;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            RegAdhLow:  adh_low_ff  <= csr_chan.data;
            RegAdhHigh: adh_high_ff <= csr_chan.data;
            RegMinFill: min_fill_ff <= csr_chan.data[FillW-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [AdhW-1:0] adhesion_of(input logic [MatW-1:0] mat,
                                                   input logic [CsrDataW-1:0] lo,
                                                   input logic [CsrDataW-1:0] hi);
      logic [CsrDataW-1:0] r;
      r = mat[2] ? hi : lo;
      if (int'(mat) >= MATERIAL_COUNT) return '0;
      return r[mat[1:0]*AdhW +: AdhW];
   endfunction

   // Grid memory
   logic [CellW-1:0] grid_mem [Depth];
   logic             mem_we;
   logic [AddrW-1:0] mem_wa, mem_ra;
   logic [CellW-1:0] mem_wd, mem_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= grid_mem[mem_ra];
   end

   // Datapath registers
   logic [AddrW-1:0]         clr_ff, clr_in;
   logic [CoordW-1:0]        qx_ff, qy_ff;
   logic [MatW-1:0]          cm_ff;
   logic [FillW-1:0]         cf_ff;
   logic [AdhW-1:0]          ca_ff;
   logic [NbIdxW-1:0]        k_ff, k_in;
   logic [MatW-1:0]          nm_ff;
   logic [FillW-1:0]         nf_ff;
   logic [2*AdhW-1:0]        prod_ff;
   logic [AdhW-1:0]          m_ff;
   logic [AdhW+FillW-1:0]    p1_ff;
   logic [AdhW+2*FillW-1:0]  s_ff;
   logic [24+DiagW-1:0]      pp_hi_ff, pp_lo_ff;
   logic signed [AccW-1:0]   acc_x_ff, acc_y_ff;
   logic [AdhW-1:0]          max_m_ff;
   logic [MatW-1:0]          strong_ff;
   logic [CountW-1:0]        count_ff;
   logic signed [ForceW-1:0] sat_x_ff, sat_y_ff;
   logic [2*ForceW-1:0]      sq_x_ff, sq_y_ff;
   logic [ForceW-1:0]        mag_ff;

   // Square root unit
   logic                      sqrt_start;
   logic [SqrtInW-1:0]        sqrt_rad;
   sqrt_status_type           sqrt_status;
   logic [SqrtOutW-1:0]       sqrt_root;

   gnaf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .status   (sqrt_status),
      .root     (sqrt_root)
   );

   // Request address and bounds
   logic req_inside, req_acc;
   logic [AddrW-1:0] req_addr;
   assign req_inside = int'(req_chan.cell_x) < GRID_WIDTH && int'(req_chan.cell_y) < GRID_HEIGHT;
   assign req_addr   = AddrW'(int'(req_chan.cell_y) * GRID_WIDTH + int'(req_chan.cell_x));
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc    = req_chan.valid && req_chan.ready;

   // Neighbor position
   offset_type         off;
   logic signed [NbW-1:0] nx, ny;
   logic               nb_inside;
   logic [AddrW-1:0]   nb_addr;
   always_comb begin
      off = nb_offset(k_ff);
      nx  = $signed({{(NbW-CoordW){1'b0}}, qx_ff}) + NbW'(off.dx);
      ny  = $signed({{(NbW-CoordW){1'b0}}, qy_ff}) + NbW'(off.dy);
      nb_inside = (nx >= 0) && (ny >= 0) && (int'(nx) < GRID_WIDTH) && (int'(ny) < GRID_HEIGHT);
      nb_addr = AddrW'(int'(ny) * GRID_WIDTH + int'(nx));
   end

   // Contact qualification
   logic [MatW-1:0]  rd_mat;
   logic [FillW-1:0] rd_fill;
   logic             qualify;
   assign rd_mat  = mem_rd_ff[CellW-1 -: MatW];
   assign rd_fill = mem_rd_ff[FillW-1:0];
   assign qualify = (rd_mat != cm_ff) && (rd_fill > min_fill_ff);

   // Contribution of the current contact
   logic                          diag;
   logic [48+DiagW:0]             diag_sum;
   logic [FillW-1:0]              part;
   logic signed [AccW-1:0]        part_s;
   always_comb begin
      diag     = (off.dx != 2'sd0) && (off.dy != 2'sd0);
      diag_sum = {1'b0, pp_hi_ff, 24'd0} + (49+DiagW)'(pp_lo_ff);
      part     = diag ? diag_sum[48 +: FillW] : s_ff[32 +: FillW];
      part_s   = $signed({{(AccW-FillW){1'b0}}, part});
   end

   function automatic logic signed [ForceW-1:0] sat_force(input logic signed [AccW-1:0] v);
      if (v > AccW'(ForceMax)) return ForceW'(ForceMax);
      if (v < AccW'(ForceMin)) return ForceW'(ForceMin);
      return v[ForceW-1:0];
   endfunction

   // Saturated components and their magnitudes
   logic signed [ForceW-1:0] sat_x_c, sat_y_c;
   logic [ForceW-1:0]        abs_x, abs_y;
   always_comb begin
      sat_x_c = sat_force(acc_x_ff);
      sat_y_c = sat_force(acc_y_ff);
      abs_x   = sat_x_c[ForceW-1] ? $unsigned(-sat_x_c) : $unsigned(sat_x_c);
      abs_y   = sat_y_c[ForceW-1] ? $unsigned(-sat_y_c) : $unsigned(sat_y_c);
   end

   // Response register
   logic rsp_valid_ff;
   logic out_load;
   assign out_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      k_in       = k_ff;
      mem_we     = 1'b0;
      mem_wa     = req_addr;
      mem_wd     = {req_chan.material_code, req_chan.fill_fraction};
      mem_ra     = (state_ff == S_IDLE) ? req_addr : nb_addr;
      sqrt_start = 1'b0;
      sqrt_rad   = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (int'(clr_ff) == Depth - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_chan.command == CmdWrite) begin
                  mem_we = req_inside;
               end else if (req_inside) begin
                  state_in = S_CENTER;
               end else begin
                  state_in = S_MAG_SQ;
               end
            end
         end
         S_CENTER: begin
            k_in = '0;
            if (rd_mat == '0 || rd_fill == '0) state_in = S_MAG_SQ;
            else state_in = S_NB_ADDR;
         end
         S_NB_ADDR: begin
            if (nb_inside) state_in = S_NB_DATA;
            else if (k_ff == NbIdxW'(NbCount - 1)) state_in = S_MAG_SQ;
            else k_in = k_ff + 1'b1;
         end
         S_NB_DATA: begin
            if (qualify) state_in = S_ADH_MUL;
            else if (k_ff == NbIdxW'(NbCount - 1)) state_in = S_MAG_SQ;
            else begin
               k_in     = k_ff + 1'b1;
               state_in = S_NB_ADDR;
            end
         end
         S_ADH_MUL:   state_in = S_ADH_START;
         S_ADH_START: begin
            sqrt_start = 1'b1;
            sqrt_rad   = SqrtInW'(prod_ff);
            state_in   = S_ADH_SQRT;
         end
         S_ADH_SQRT:  if (sqrt_status.done) state_in = S_SCL_MUL1;
         S_SCL_MUL1:  state_in = S_SCL_MUL2;
         S_SCL_MUL2:  state_in = S_DIAG_MUL;
         S_DIAG_MUL:  state_in = S_ACCUM;
         S_ACCUM: begin
            if (k_ff == NbIdxW'(NbCount - 1)) state_in = S_MAG_SQ;
            else begin
               k_in     = k_ff + 1'b1;
               state_in = S_NB_ADDR;
            end
         end
         S_MAG_SQ:    state_in = S_MAG_START;
         S_MAG_START: begin
            sqrt_start = 1'b1;
            sqrt_rad   = SqrtInW'(sq_x_ff) + SqrtInW'(sq_y_ff);
            state_in   = S_MAG_SQRT;
         end
         S_MAG_SQRT:  if (sqrt_status.done) state_in = S_FINISH;
         S_FINISH:    if (out_load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Datapath updates
   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (req_acc) begin
         qx_ff     <= req_chan.cell_x;
         qy_ff     <= req_chan.cell_y;
         acc_x_ff  <= '0;
         acc_y_ff  <= '0;
         max_m_ff  <= '0;
         strong_ff <= '0;
         count_ff  <= '0;
      end
      if (state_ff == S_CENTER) begin
         cm_ff <= rd_mat;
         cf_ff <= rd_fill;
         ca_ff <= adhesion_of(rd_mat, adh_low_ff, adh_high_ff);
      end
      if (state_ff == S_NB_DATA) begin
         nm_ff <= rd_mat;
         nf_ff <= rd_fill;
      end
      if (state_ff == S_ADH_MUL) begin
         prod_ff <= (2*AdhW)'(ca_ff) *
                    (2*AdhW)'(adhesion_of(nm_ff, adh_low_ff, adh_high_ff));
      end
      if (state_ff == S_ADH_SQRT && sqrt_status.done) begin
         m_ff <= sqrt_root[AdhW-1:0];
      end
      if (state_ff == S_SCL_MUL1) p1_ff <= (AdhW+FillW)'(m_ff) * (AdhW+FillW)'(nf_ff);
      if (state_ff == S_SCL_MUL2) s_ff  <= (AdhW+2*FillW)'(p1_ff) * (AdhW+2*FillW)'(cf_ff);
      if (state_ff == S_DIAG_MUL) begin
         pp_hi_ff <= (24+DiagW)'(s_ff[47:24]) * (24+DiagW)'(DiagWeight);
         pp_lo_ff <= (24+DiagW)'(s_ff[23:0]) * (24+DiagW)'(DiagWeight);
      end
      // Add the contact along its direction and track the strongest one
      if (state_ff == S_ACCUM) begin
         if (off.dx > 0) acc_x_ff <= acc_x_ff + part_s;
         else if (off.dx < 0) acc_x_ff <= acc_x_ff - part_s;
         if (off.dy > 0) acc_y_ff <= acc_y_ff + part_s;
         else if (off.dy < 0) acc_y_ff <= acc_y_ff - part_s;
         count_ff <= count_ff + 1'b1;
         if (m_ff > max_m_ff) begin
            max_m_ff  <= m_ff;
            strong_ff <= nm_ff;
         end
      end
      if (state_ff == S_MAG_SQ) begin
         sat_x_ff <= sat_x_c;
         sat_y_ff <= sat_y_c;
         sq_x_ff  <= (2*ForceW)'(abs_x) * (2*ForceW)'(abs_x);
         sq_y_ff  <= (2*ForceW)'(abs_y) * (2*ForceW)'(abs_y);
      end
      if (state_ff == S_MAG_SQRT && sqrt_status.done) mag_ff <= sqrt_root;
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   logic signed [ForceW-1:0] out_fx_ff, out_fy_ff;
   logic [ForceW-1:0]        out_mag_ff;
   logic [MatW-1:0]          out_strong_ff;
   logic [CountW-1:0]        out_count_ff;
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_fx_ff     <= sat_x_ff;
         out_fy_ff     <= sat_y_ff;
         out_mag_ff    <= mag_ff;
         out_strong_ff <= strong_ff;
         out_count_ff  <= count_ff;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.force_x            = out_fx_ff;
   assign rsp_chan.force_y            = out_fy_ff;
   assign rsp_chan.force_magnitude    = out_mag_ff;
   assign rsp_chan.strongest_material = out_strong_ff;
   assign rsp_chan.contact_total      = out_count_ff;

   // Checks
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_chan.ready)
      else $error("item accepted during clearing pass");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.contact_total <= CountW'(NbCount))
      else $error("contact count above eight");

   a_sqrt_idle_start: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_status.busy)
      else $error("square root started while busy");

   a_sqrt_done_wait: assert property (@(posedge clock) disable iff (reset)
      sqrt_status.done |-> (state_ff == S_ADH_SQRT || state_ff == S_MAG_SQRT))
      else $error("square root result with no consumer");

endmodule
`default_nettype wire
